>>> rtl/four_lane_byte_hash_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-lane byte hash core
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FOUR_LANE_BYTE_HASH_CORE_DEFINES_SVH
`define FOUR_LANE_BYTE_HASH_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLBH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FLBH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/flbh_pkg.sv
// ----------------------------------------------------------------------------
// flbh_pkg
// Types, constants and small helpers shared by the four-lane byte hash.
// ----------------------------------------------------------------------------
package flbh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       finish;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Request to and response from the shared multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

    localparam logic [63:0] GOLDEN    = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
    localparam logic [63:0] SMIX_M1   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] SMIX_M2   = 64'h94d0_49bb_1331_11eb;

    localparam logic [3:0][63:0] LANE_INIT = {
        64'h082e_fa98_ec4e_6c89,
        64'ha409_3822_299f_31d0,
        64'h1319_8a2e_0370_7344,
        64'h243f_6a88_85a3_08d3
    };

    // Rotation after the prime multiply is 11 + 7 * lane.
    localparam logic [3:0][5:0] LANE_ROT = {6'd32, 6'd25, 6'd18, 6'd11};

    localparam logic [5:0] ROT_W0 = 6'd17;
    localparam logic [5:0] ROT_W1 = 6'd29;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] sh);
        logic [6:0] rsh;
        rsh    = 7'd64 - {1'b0, sh};
        rotl64 = (v << sh) | (v >> rsh);
    endfunction

endpackage

>>> rtl/four_lane_byte_hash_core.sv
// ----------------------------------------------------------------------------
// four_lane_byte_hash_core
// 256-bit byte-stream digest over four 64-bit lanes, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage: items enter on item/item_valid/item_ready. An item carries an
// optional byte (byte_valid) and a finish flag. An item with neither is taken
// while the block stays idle and changes nothing. A byte holds item_ready low
// until it has been worked in, so a new byte is not taken before the block is
// through with the last; the work is three 64-bit multiplies in a row on the
// single 32 x 32 multiplier, plus a step to form the sum and one to start the
// mix. A finish then rotates the lane bank back into order and forms the four
// digest words in turn, each with its own load and mix.
// Digest words leave on word/word_valid/word_ready, word_index 0 to 3, with
// last_word on the fourth. A stalled receiver holds the output register; the
// block waits before loading the next word but keeps its work otherwise.
// item_ready is high only between items, and may be high while the last
// digest word is still waiting to be taken.
// Reset clears the lanes to their initial constants and the length to zero;
// after a finish the same state is restored once the last word is loaded.
// ----------------------------------------------------------------------------
module four_lane_byte_hash_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  flbh_pkg::in_item_t  item,
    output logic                word_valid,
    input  logic                word_ready,
    output flbh_pkg::out_item_t word
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_WAIT_FNV,
        ST_SMIX_A,
        ST_WAIT_A,
        ST_WAIT_B,
        ST_ALIGN,
        ST_FIN_LOAD,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [3:0][63:0]    lane_reg, lane_next;
    logic [1:0]          offset_reg, offset_next;
    logic [63:0]         count_reg, count_next;
    logic [63:0]         sum_reg, sum_next;
    logic [63:0]         t_reg, t_next;
    logic [63:0]         w_reg, w_next;
    logic [63:0]         w0_reg, w0_next;
    logic [63:0]         w1_reg, w1_next;
    logic [7:0]          byte_reg, byte_next;
    logic                fin_reg, fin_next;
    logic                final_reg, final_next;
    logic [1:0]          idx_reg, idx_next;
    logic                word_valid_reg, word_valid_next;
    flbh_pkg::out_item_t word_reg, word_next;

    flbh_pkg::mul_req_t  mul_req;
    flbh_pkg::mul_rsp_t  mul_rsp;

    logic [63:0]         sum_v;
    logic [63:0]         rot_v;
    logic [63:0]         prod;
    logic [63:0]         mix_v;
    logic                word_free;

    flbh_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // The lane bank is kept rotated so that the lane being written sits in
    // slot 0 and the lane that takes the mix sits in slot 1.
    always_comb
    begin
        state_next      = state_reg;
        lane_next       = lane_reg;
        offset_next     = offset_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        t_next          = t_reg;
        w_next          = w_reg;
        w0_next         = w0_reg;
        w1_next         = w1_reg;
        byte_next       = byte_reg;
        fin_next        = fin_reg;
        final_next      = final_reg;
        idx_next        = idx_reg;
        word_valid_next = word_valid_reg;
        word_next       = word_reg;
        mul_req         = '0;

        prod      = mul_rsp.product;
        sum_v     = {56'd0, byte_reg} + flbh_pkg::GOLDEN + count_reg;
        rot_v     = flbh_pkg::rotl64(prod, flbh_pkg::LANE_ROT[count_reg[1:0]]);
        mix_v     = prod ^ (prod >> 31);
        word_free = !word_valid_reg || word_ready;

        if (word_valid_reg && word_ready)
        begin
            word_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    byte_next = item.data_byte;
                    fin_next  = item.finish;
                    idx_next  = 2'd0;
                    if (item.byte_valid)
                    begin
                        state_next = ST_SUM;
                    end
                    else if (item.finish)
                    begin
                        state_next = ST_ALIGN;
                    end
                end
            end

            ST_SUM:
            begin
                sum_next      = sum_v;
                mul_req.start = 1'b1;
                mul_req.a     = lane_reg[0] ^ sum_v;
                mul_req.b     = flbh_pkg::FNV_PRIME;
                state_next    = ST_WAIT_FNV;
            end

            ST_WAIT_FNV:
            begin
                if (mul_rsp.done)
                begin
                    lane_next[0] = rot_v;
                    t_next       = rot_v + sum_reg;
                    state_next   = ST_SMIX_A;
                end
            end

            ST_SMIX_A:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = t_reg ^ (t_reg >> 30);
                mul_req.b     = flbh_pkg::SMIX_M1;
                state_next    = ST_WAIT_A;
            end

            ST_WAIT_A:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = prod ^ (prod >> 27);
                    mul_req.b     = flbh_pkg::SMIX_M2;
                    state_next    = ST_WAIT_B;
                end
            end

            ST_WAIT_B:
            begin
                if (mul_rsp.done)
                begin
                    if (!final_reg)
                    begin
                        // Mix into the next lane and advance the bank by one.
                        lane_next[0] = lane_reg[1] ^ mix_v;
                        lane_next[1] = lane_reg[2];
                        lane_next[2] = lane_reg[3];
                        lane_next[3] = lane_reg[0];
                        offset_next  = offset_reg + 2'd1;
                        count_next   = count_reg + 64'd1;
                        state_next   = fin_reg ? ST_ALIGN : ST_IDLE;
                    end
                    else
                    begin
                        w_next = mix_v;
                        if (idx_reg == 2'd0)
                        begin
                            w0_next = mix_v;
                        end
                        if (idx_reg == 2'd1)
                        begin
                            w1_next = mix_v;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_ALIGN:
            begin
                if (offset_reg == 2'd0)
                begin
                    state_next = ST_FIN_LOAD;
                end
                else
                begin
                    lane_next[0] = lane_reg[1];
                    lane_next[1] = lane_reg[2];
                    lane_next[2] = lane_reg[3];
                    lane_next[3] = lane_reg[0];
                    offset_next  = offset_reg + 2'd1;
                end
            end

            ST_FIN_LOAD:
            begin
                final_next = 1'b1;
                state_next = ST_SMIX_A;
                unique case (idx_reg)
                    2'd0: t_next = lane_reg[0] ^ count_reg ^ lane_reg[2];
                    2'd1: t_next = lane_reg[1] + count_reg + lane_reg[3];
                    2'd2: t_next = lane_reg[2] ^ flbh_pkg::rotl64(w0_reg, flbh_pkg::ROT_W0);
                    default: t_next = lane_reg[3] + flbh_pkg::rotl64(w1_reg, flbh_pkg::ROT_W1);
                endcase
            end

            ST_EMIT:
            begin
                if (word_free)
                begin
                    word_valid_next       = 1'b1;
                    word_next.digest_word = w_reg;
                    word_next.word_index  = idx_reg;
                    word_next.last_word   = (idx_reg == 2'd3);
                    if (idx_reg == 2'd3)
                    begin
                        lane_next   = flbh_pkg::LANE_INIT;
                        offset_next = 2'd0;
                        count_next  = 64'd0;
                        final_next  = 1'b0;
                        fin_next    = 1'b0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_FIN_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lane_reg       <= flbh_pkg::LANE_INIT;
            offset_reg     <= 2'd0;
            count_reg      <= 64'd0;
            sum_reg        <= 64'd0;
            t_reg          <= 64'd0;
            w_reg          <= 64'd0;
            w0_reg         <= 64'd0;
            w1_reg         <= 64'd0;
            byte_reg       <= 8'd0;
            fin_reg        <= 1'b0;
            final_reg      <= 1'b0;
            idx_reg        <= 2'd0;
            word_valid_reg <= 1'b0;
            word_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            lane_reg       <= lane_next;
            offset_reg     <= offset_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            t_reg          <= t_next;
            w_reg          <= w_next;
            w0_reg         <= w0_next;
            w1_reg         <= w1_next;
            byte_reg       <= byte_next;
            fin_reg        <= fin_next;
            final_reg      <= final_next;
            idx_reg        <= idx_next;
            word_valid_reg <= word_valid_next;
            word_reg       <= word_next;
        end
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign word_valid = word_valid_reg;
    assign word       = word_reg;

endmodule

>>> rtl/flbh_mul.sv
// ----------------------------------------------------------------------------
// flbh_mul
// 64 x 64 multiplier keeping the low 64 bits, built from one 32 x 32
// multiplier used over three partial products.
// ----------------------------------------------------------------------------
module flbh_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  flbh_pkg::mul_req_t req,
    output flbh_pkg::mul_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic [1:0]  step_reg, step_next;
    logic        done_reg, done_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] pp_reg, pp_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] opx;
    logic [31:0] opy;
    logic [63:0] pp_prod;

    // Low part first, then the two cross terms, which only reach the top half.
    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                opx = a_reg[31:0];
                opy = b_reg[31:0];
            end
            2'd1:
            begin
                opx = a_reg[31:0];
                opy = b_reg[63:32];
            end
            default:
            begin
                opx = a_reg[63:32];
                opy = b_reg[31:0];
            end
        endcase
        pp_prod = opx * opy;
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        pp_next   = pp_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            busy_next = 1'b1;
            step_next = 2'd0;
        end
        else if (busy_reg)
        begin
            pp_next   = pp_prod;
            step_next = step_reg + 2'd1;
            unique case (step_reg)
                2'd0: acc_next = acc_reg;
                2'd1: acc_next = pp_reg;
                2'd2: acc_next = acc_reg + {pp_reg[31:0], 32'd0};
                default:
                begin
                    acc_next  = acc_reg + {pp_reg[31:0], 32'd0};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

>>> rtl/flbh_checker.sv
// ----------------------------------------------------------------------------
// flbh_checker
// Port-level checks on the four-lane byte hash core, bound to the top level.
// ----------------------------------------------------------------------------
`include "four_lane_byte_hash_core_defines.svh"

module flbh_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input flbh_pkg::in_item_t  item,
    input logic                word_valid,
    input logic                word_ready,
    input flbh_pkg::out_item_t word
);

    `FLBH_ASSERT_NEXT(a_word_hold, word_valid && !word_ready,
                      word_valid && $stable(word), "digest word changed while stalled")

    // Any item that does work leaves the block busy in the cycle after it is taken.
    `FLBH_ASSERT_NEXT(a_busy_after_work,
                      item_valid && item_ready && (item.byte_valid || item.finish),
                      !item_ready, "block ready straight after a working item")

    `FLBH_ASSERT_SAME(a_last_is_fourth, word_valid,
                      word.last_word == (word.word_index == 2'd3),
                      "last_word does not match word_index")

    // No new item is taken while a digest is only partly delivered.
    `FLBH_ASSERT_SAME(a_busy_mid_digest, word_valid && !word.last_word, !item_ready,
                      "block ready in the middle of a digest")

endmodule

bind four_lane_byte_hash_core flbh_checker u_flbh_checker (.*);
